FILE: rtl/mcob_pkg.sv
// Shared types and constants for the multi-channel oscillator bank.
// Used by mcob_mac and multi_channel_oscillator_bank_top; no dependencies.
`timescale 1ns / 1ps

package mcob_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam int DATA_W = 16;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int FRAC_W = 14;

    localparam logic signed [DATA_W-1:0] ONE_Q14     = 16'sh4000;
    localparam logic signed [DATA_W-1:0] NEG_ONE_Q14 = -16'sh4000;
    localparam logic signed [DATA_W-1:0] MAX_Q14     = 16'sh7FFF;
    localparam logic [DATA_W-1:0]        HALF_TURN   = 16'h8000;

    localparam int CD_W = 14;

    // Waveform codes
    localparam logic [1:0] WAVE_SQUARE   = 2'd0;
    localparam logic [1:0] WAVE_SINE     = 2'd1;
    localparam logic [1:0] WAVE_SAW      = 2'd2;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd3;

    // Opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_PWM_WRAP     = 2'd0;
    localparam logic [1:0] REG_PWM_CENTER   = 2'd1;
    localparam logic [1:0] REG_OUTPUT_SHIFT = 2'd2;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic    mul_en;
        acc_op_t op;
    } mac_ctrl_t;

endpackage

FILE: rtl/mcob_mac.sv
// Shared signed 16x16 multiplier with a registered product and an accumulator.
// Depends on mcob_pkg for widths and the control struct.
`timescale 1ns / 1ps

module mcob_mac
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mcob_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [mcob_pkg::DATA_W-1:0]    op_a,
    input  logic signed [mcob_pkg::DATA_W-1:0]    op_b,
    output logic signed [mcob_pkg::ACC_W-1:0]     acc
);

    logic signed [mcob_pkg::PROD_W-1:0] prod_reg;
    logic signed [mcob_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mcob_pkg::ACC_W-1:0]  prod_ext;

    assign prod_ext = {prod_reg[mcob_pkg::PROD_W-1], prod_reg};
    assign acc      = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (ctrl.mul_en)
            begin
                prod_reg <= op_a * op_b;
            end
            unique case (ctrl.op)
                mcob_pkg::ACC_HOLD: acc_reg <= acc_reg;
                mcob_pkg::ACC_LOAD: acc_reg <= prod_ext;
                mcob_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_ext;
                mcob_pkg::ACC_SUB:  acc_reg <= acc_reg - prod_ext;
                default:            acc_reg <= acc_reg;
            endcase
        end
    end

endmodule

FILE: rtl/multi_channel_oscillator_bank_top.sv
// Channel         Handshake            Payload
// s (input)       s_tvalid/s_tready    s_tuser: opcode; s_tdata: channel load fields
// m (result)      m_tvalid/m_tready    m_tdata: pwm_level, sample
// cfg (registers) cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load transaction writes one channel and the block stays idle. A tick walks the
// channels through one shared multiplier: rotating channels through the multiply
// phases, ramp channels through a move and a wrap step, then the output step posts
// the result; a renormalizing tick then normalizes rotating channels in ST_NORM. The
// result sits in an output register, so a stalled m side holds the block only when a
// second result is ready. Async reset returns all channels to a zeroed sine state.
`timescale 1ns / 1ps

module multi_channel_oscillator_bank_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // channel[2:0], waveform[4:3], init_real[20:5],
                                   // init_imag[36:21], step_real[52:37], step_imag[68:53]
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pwm_level[15:0], sample[31:16]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADV,
        ST_OUT,
        ST_NORM
    } state_t;

    localparam int DW = mcob_pkg::DATA_W;
    localparam int FW = mcob_pkg::FRAC_W;
    localparam int CW = mcob_pkg::CH_W;

    state_t state_reg;
    logic [2:0]            ph_reg;
    logic [CW-1:0]         k_reg;
    logic signed [DW-1:0]  nr_reg;
    logic signed [DW-1:0]  gain_reg;
    logic [mcob_pkg::CD_W-1:0] cd_reg;
    logic [15:0]           pwm_wrap_reg;
    logic [15:0]           pwm_center_reg;
    logic [3:0]            shift_reg;
    logic                  m_tvalid_reg;
    logic [31:0]           m_tdata_reg;

    logic signed [DW-1:0] chan_real_reg      [mcob_pkg::NUM_CHANNELS];
    logic signed [DW-1:0] chan_imag_reg      [mcob_pkg::NUM_CHANNELS];
    logic signed [DW-1:0] chan_step_real_reg [mcob_pkg::NUM_CHANNELS];
    logic signed [DW-1:0] chan_step_imag_reg [mcob_pkg::NUM_CHANNELS];
    logic [1:0]           chan_wave_reg      [mcob_pkg::NUM_CHANNELS];

    // Input field unpacking
    logic [2:0]           in_channel;
    logic [1:0]           in_wave;
    logic signed [DW-1:0] in_init_real;
    logic signed [DW-1:0] in_init_imag;
    logic signed [DW-1:0] in_step_real;
    logic signed [DW-1:0] in_step_imag;

    assign in_channel   = s_tdata[2:0];
    assign in_wave      = s_tdata[4:3];
    assign in_init_real = s_tdata[20:5];
    assign in_init_imag = s_tdata[36:21];
    assign in_step_real = s_tdata[52:37];
    assign in_step_imag = s_tdata[68:53];

    logic s_fire;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Current channel operands
    logic signed [DW-1:0] cur_r, cur_i, cur_cr, cur_ci;
    logic [1:0]           cur_wave;
    logic                 cur_rot;
    logic                 last_ch;

    assign cur_r    = chan_real_reg[k_reg];
    assign cur_i    = chan_imag_reg[k_reg];
    assign cur_cr   = chan_step_real_reg[k_reg];
    assign cur_ci   = chan_step_imag_reg[k_reg];
    assign cur_wave = chan_wave_reg[k_reg];
    assign cur_rot  = !cur_wave[1];
    assign last_ch  = (k_reg == CW'(mcob_pkg::NUM_CHANNELS - 1));

    // Shared multiplier schedule
    mcob_pkg::mac_ctrl_t  mac_ctrl;
    logic signed [DW-1:0] mac_a, mac_b;
    logic signed [mcob_pkg::ACC_W-1:0] mac_acc;
    logic signed [DW-1:0] acc_q14;

    assign acc_q14 = mac_acc[FW+DW-1:FW];

    always_comb
    begin
        mac_ctrl.mul_en = 1'b0;
        mac_ctrl.op     = mcob_pkg::ACC_HOLD;
        mac_a           = cur_r;
        mac_b           = cur_cr;
        if (state_reg == ST_ADV && cur_rot)
        begin
            unique case (ph_reg)
                3'd0:
                begin
                    mac_ctrl.mul_en = 1'b1;
                end
                3'd1:
                begin
                    mac_ctrl.mul_en = 1'b1;
                    mac_ctrl.op     = mcob_pkg::ACC_LOAD;
                    mac_a           = cur_i;
                    mac_b           = cur_ci;
                end
                3'd2:
                begin
                    mac_ctrl.mul_en = 1'b1;
                    mac_ctrl.op     = mcob_pkg::ACC_SUB;
                    mac_a           = cur_i;
                    mac_b           = cur_cr;
                end
                3'd3:
                begin
                    mac_ctrl.mul_en = 1'b1;
                    mac_ctrl.op     = mcob_pkg::ACC_LOAD;
                    mac_a           = cur_r;
                    mac_b           = cur_ci;
                end
                3'd4:
                begin
                    mac_ctrl.op = mcob_pkg::ACC_ADD;
                end
                default:
                begin
                    mac_ctrl.op = mcob_pkg::ACC_HOLD;
                end
            endcase
        end
        else if (state_reg == ST_NORM)
        begin
            unique case (ph_reg)
                3'd0:
                begin
                    mac_ctrl.mul_en = 1'b1;
                    mac_a           = cur_r;
                    mac_b           = cur_r;
                end
                3'd1:
                begin
                    mac_ctrl.mul_en = 1'b1;
                    mac_ctrl.op     = mcob_pkg::ACC_LOAD;
                    mac_a           = cur_i;
                    mac_b           = cur_i;
                end
                3'd2:
                begin
                    mac_ctrl.op = mcob_pkg::ACC_ADD;
                end
                3'd4:
                begin
                    mac_ctrl.mul_en = 1'b1;
                    mac_a           = cur_r;
                    mac_b           = gain_reg;
                end
                3'd5:
                begin
                    mac_ctrl.mul_en = 1'b1;
                    mac_ctrl.op     = mcob_pkg::ACC_LOAD;
                    mac_a           = cur_i;
                    mac_b           = gain_reg;
                end
                3'd6:
                begin
                    mac_ctrl.op = mcob_pkg::ACC_LOAD;
                end
                default:
                begin
                    mac_ctrl.op = mcob_pkg::ACC_HOLD;
                end
            endcase
        end
    end

    mcob_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .acc   (mac_acc)
    );

    // Ramp step: phase 0 moves the position, phase 1 wraps or reflects it.
    logic                 ramp_down;
    logic                 ramp_hit;
    logic signed [DW-1:0] ramp_pos;
    logic signed [DW-1:0] ramp_fixed;

    assign ramp_down = cur_ci[DW-1];
    assign ramp_pos  = ramp_down ? (cur_r - cur_cr) : (cur_r + cur_cr);
    assign ramp_hit  = ramp_down ? (nr_reg <= mcob_pkg::NEG_ONE_Q14)
                                 : (nr_reg >= mcob_pkg::ONE_Q14);

    always_comb
    begin
        ramp_fixed = nr_reg;
        if (ramp_hit)
        begin
            // Both reflections and both wraps reduce to a half-turn offset mod 2^16.
            if (cur_wave == mcob_pkg::WAVE_TRIANGLE)
            begin
                ramp_fixed = mcob_pkg::HALF_TURN - nr_reg;
            end
            else
            begin
                ramp_fixed = nr_reg + mcob_pkg::HALF_TURN;
            end
        end
    end

    // PWM level from channel 0
    logic signed [DW-1:0] r0;
    logic [15:0]          mag;
    logic [15:0]          mag_sh;
    logic [17:0]          lvl_sum;
    logic [15:0]          level;

    assign r0      = chan_real_reg[0];
    assign mag     = r0[DW-1] ? (~r0 + 16'd1) : r0;
    assign mag_sh  = mag >> shift_reg;
    assign lvl_sum = r0[DW-1] ? ({2'b00, pwm_center_reg} - {2'b00, mag_sh})
                              : ({2'b00, pwm_center_reg} + {2'b00, mag_sh});

    always_comb
    begin
        if (chan_wave_reg[0] == mcob_pkg::WAVE_SQUARE)
        begin
            if (r0[DW-1])
            begin
                level = 16'd0;
            end
            else if (pwm_wrap_reg == 16'hFFFF)
            begin
                level = 16'hFFFF;
            end
            else
            begin
                level = pwm_wrap_reg + 16'd1;
            end
        end
        else if (lvl_sum[17])
        begin
            level = 16'd0;
        end
        else if (lvl_sum[16])
        begin
            level = 16'hFFFF;
        end
        else
        begin
            level = lvl_sum[15:0];
        end
    end

    // Renormalization countdown
    logic [mcob_pkg::CD_W-1:0] cd_dec;
    logic [3:0]                cd_exp;
    logic [mcob_pkg::CD_W-1:0] cd_reload;

    assign cd_dec = cd_reg - 1'b1;

    always_comb
    begin
        if (shift_reg == 4'd0)
        begin
            cd_exp = 4'd0;
        end
        else if (shift_reg > 4'd14)
        begin
            cd_exp = 4'd13;
        end
        else
        begin
            cd_exp = shift_reg - 4'd1;
        end
    end

    assign cd_reload = mcob_pkg::CD_W'(1) << cd_exp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ph_reg         <= '0;
            k_reg          <= '0;
            nr_reg         <= '0;
            gain_reg       <= '0;
            cd_reg         <= mcob_pkg::CD_W'(1);
            pwm_wrap_reg   <= 16'd255;
            pwm_center_reg <= 16'd128;
            shift_reg      <= 4'd7;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            for (int c = 0; c < mcob_pkg::NUM_CHANNELS; c++)
            begin
                chan_real_reg[c]      <= '0;
                chan_imag_reg[c]      <= '0;
                chan_step_real_reg[c] <= '0;
                chan_step_imag_reg[c] <= '0;
                chan_wave_reg[c]      <= mcob_pkg::WAVE_SINE;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    mcob_pkg::REG_PWM_WRAP:     pwm_wrap_reg   <= cfg_data;
                    mcob_pkg::REG_PWM_CENTER:   pwm_center_reg <= cfg_data;
                    mcob_pkg::REG_OUTPUT_SHIFT: shift_reg      <= cfg_data[3:0];
                    default:                    ;
                endcase
            end

            // The output step decides the valid flag itself.
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        if (s_tuser == mcob_pkg::OP_LOAD)
                        begin
                            if (32'(in_channel) < mcob_pkg::NUM_CHANNELS)
                            begin
                                chan_wave_reg[CW'(in_channel)]      <= in_wave;
                                chan_real_reg[CW'(in_channel)]      <= in_init_real;
                                chan_imag_reg[CW'(in_channel)]      <= in_init_imag;
                                chan_step_real_reg[CW'(in_channel)] <= in_step_real;
                                chan_step_imag_reg[CW'(in_channel)] <= in_step_imag;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_ADV;
                            ph_reg    <= '0;
                            k_reg     <= '0;
                        end
                    end
                end

                ST_ADV:
                begin
                    if (cur_rot)
                    begin
                        if (ph_reg == 3'd3)
                        begin
                            nr_reg <= acc_q14;
                        end
                        if (ph_reg == 3'd5)
                        begin
                            chan_real_reg[k_reg] <= nr_reg;
                            chan_imag_reg[k_reg] <= acc_q14;
                            ph_reg               <= '0;
                            k_reg                <= last_ch ? '0 : k_reg + 1'b1;
                            if (last_ch)
                            begin
                                state_reg <= ST_OUT;
                            end
                        end
                        else
                        begin
                            ph_reg <= ph_reg + 3'd1;
                        end
                    end
                    else if (ph_reg == 3'd0)
                    begin
                        nr_reg <= ramp_pos;
                        ph_reg <= 3'd1;
                    end
                    else
                    begin
                        chan_real_reg[k_reg] <= ramp_fixed;
                        if (ramp_hit && cur_wave == mcob_pkg::WAVE_TRIANGLE)
                        begin
                            chan_step_imag_reg[k_reg] <= ramp_down ? mcob_pkg::ONE_Q14
                                                                   : mcob_pkg::NEG_ONE_Q14;
                        end
                        ph_reg <= '0;
                        k_reg  <= last_ch ? '0 : k_reg + 1'b1;
                        if (last_ch)
                        begin
                            state_reg <= ST_OUT;
                        end
                    end
                end

                ST_OUT:
                begin
                    // Wait only if the previous result has not been taken yet.
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {r0, level};
                        if (cd_dec == '0)
                        begin
                            cd_reg    <= cd_reload;
                            state_reg <= ST_NORM;
                        end
                        else
                        begin
                            cd_reg    <= cd_dec;
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                ST_NORM:
                begin
                    if (ph_reg == 3'd0 && !cur_rot)
                    begin
                        k_reg <= last_ch ? '0 : k_reg + 1'b1;
                        if (last_ch)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else if (ph_reg == 3'd7)
                    begin
                        chan_real_reg[k_reg] <= nr_reg;
                        chan_imag_reg[k_reg] <= acc_q14;
                        ph_reg               <= '0;
                        k_reg                <= last_ch ? '0 : k_reg + 1'b1;
                        if (last_ch)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        if (ph_reg == 3'd3)
                        begin
                            // Low 16 bits of the gain depend only on bits 29:14 of the sum.
                            gain_reg <= mcob_pkg::MAX_Q14 - acc_q14;
                        end
                        if (ph_reg == 3'd6)
                        begin
                            nr_reg <= acc_q14;
                        end
                        ph_reg <= ph_reg + 3'd1;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_tick_starts_walk : assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && s_tuser == mcob_pkg::OP_TICK |=> state_reg == ST_ADV)
        else $error("tick transaction did not start the channel walk");

    a_load_stays_idle : assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && s_tuser == mcob_pkg::OP_LOAD |=> state_reg == ST_IDLE)
        else $error("load transaction left the idle state");

    a_countdown_live : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> cd_reg != '0)
        else $error("renormalization countdown is zero while idle");

    a_result_from_out : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output step");

    a_phase_idle : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> ph_reg == '0 && k_reg == '0)
        else $error("sequencer counters not cleared at idle");

endmodule
